// ===== sv/bidc_pkg.sv =====
`timescale 1ns / 1ps

package bidc_pkg;

    localparam int ENTRIES    = 16;
    localparam int ADDR_WIDTH = 32;
    localparam int ID_WIDTH   = 32;
    localparam int IN_ADDR_W  = 32;

    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    localparam logic KIND_QUERY = 1'b0;
    localparam logic KIND_ADD   = 1'b1;

    typedef struct packed {
        logic                       kind;
        logic [IN_ADDR_W-1:0]       source_addr;
        logic signed [ID_WIDTH-1:0] broadcast_id;
    } item_t;

    typedef struct packed {
        logic is_obsolete;
        logic is_same_id;
        logic rejected;
        logic evicted;
    } result_t;

    typedef struct packed {
        logic [ADDR_WIDTH-1:0] source;
        logic [ID_WIDTH-1:0]   id;
        logic [RANK_W-1:0]     rank;
    } slot_t;

endpackage

// ===== sv/broadcast_id_duplicate_cache.sv =====
`timescale 1ns / 1ps
// a query, a rejected add and an insert into a free slot make one pass over the slot
// memory (one read per cycle) for the lookup; a replace or an evict adds a second
// read-modify-write pass that renumbers the age ranks
// one item at a time: busy is high until done, start is taken in the done cycle
// reset clears the valid bits and fill count at once; done is a strobe, no stall
module broadcast_id_duplicate_cache
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  bidc_pkg::item_t   item,
    output logic              busy,
    output logic              done,
    output bidc_pkg::result_t result
);
    import bidc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_ADJUST
    } state_t;

    state_t             state_reg;
    item_t              item_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               rd_vld_reg;
    logic [IDX_W-1:0]   rd_idx_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic [CNT_W-1:0]   used_reg;

    logic               hit_reg;
    logic [IDX_W-1:0]   hit_idx_reg;
    logic [ID_WIDTH-1:0] hit_id_reg;
    logic [RANK_W-1:0]  hit_rank_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic [IDX_W-1:0]   old_idx_reg;

    logic [IDX_W-1:0]   tgt_idx_reg;
    logic [RANK_W-1:0]  gap_reg;
    logic [RANK_W-1:0]  new_rank_reg;
    logic               evict_reg;

    logic               done_reg;
    result_t            result_reg;

    slot_t              mem [ENTRIES];
    slot_t              mem_q;
    logic               mem_rd;
    logic [IDX_W-1:0]   mem_raddr;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    slot_t              mem_wdata;

    logic [ADDR_WIDTH-1:0] src_ext;
    logic               pass_end;
    logic               rd_slot_valid;
    logic               src_match;
    logic               id_older;
    logic [CNT_W-1:0]   used_m1;

    assign src_ext       = ADDR_WIDTH'(item_reg.source_addr);
    assign pass_end      = (cnt_reg == CNT_W'(ENTRIES)) && !rd_vld_reg;
    assign rd_slot_valid = valid_reg[rd_idx_reg];
    assign src_match     = rd_slot_valid && (mem_q.source == src_ext);
    // stored id newer than the one carried by the item
    assign id_older      = $signed(hit_id_reg) > item_reg.broadcast_id;
    assign used_m1       = used_reg - CNT_W'(1);

    assign mem_rd    = (state_reg == ST_SCAN || state_reg == ST_ADJUST)
                       && (cnt_reg != CNT_W'(ENTRIES));
    assign mem_raddr = cnt_reg[IDX_W-1:0];

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = rd_idx_reg;
        mem_wdata = mem_q;
        if (state_reg == ST_SCAN && pass_end && item_reg.kind == KIND_ADD
            && !hit_reg && used_reg != CNT_W'(ENTRIES))
        begin
            // new source, free slot left
            mem_we         = 1'b1;
            mem_waddr      = free_idx_reg;
            mem_wdata.source = src_ext;
            mem_wdata.id   = item_reg.broadcast_id;
            mem_wdata.rank = used_reg[RANK_W-1:0];
        end
        else if (state_reg == ST_ADJUST && rd_vld_reg)
        begin
            if (rd_idx_reg == tgt_idx_reg)
            begin
                mem_we         = 1'b1;
                mem_wdata.source = src_ext;
                mem_wdata.id   = item_reg.broadcast_id;
                mem_wdata.rank = new_rank_reg;
            end
            else if (rd_slot_valid && mem_q.rank > gap_reg)
            begin
                // close the gap left by the entry that moves to newest
                mem_we         = 1'b1;
                mem_wdata.rank = mem_q.rank - RANK_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_rd)
        begin
            mem_q <= mem[mem_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            valid_reg      <= '0;
            used_reg       <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            evict_reg      <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg   <= 1'b0;
            rd_vld_reg <= mem_rd;
            rd_idx_reg <= mem_raddr;
            if (mem_rd)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        item_reg       <= item;
                        cnt_reg        <= '0;
                        hit_reg        <= 1'b0;
                        free_found_reg <= 1'b0;
                        state_reg      <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (rd_vld_reg)
                    begin
                        if (src_match)
                        begin
                            hit_reg      <= 1'b1;
                            hit_idx_reg  <= rd_idx_reg;
                            hit_id_reg   <= mem_q.id;
                            hit_rank_reg <= mem_q.rank;
                        end
                        if (rd_slot_valid && mem_q.rank == '0)
                        begin
                            old_idx_reg <= rd_idx_reg;
                        end
                        if (!rd_slot_valid && !free_found_reg)
                        begin
                            free_found_reg <= 1'b1;
                            free_idx_reg   <= rd_idx_reg;
                        end
                    end
                    if (pass_end)
                    begin
                        result_reg <= '0;
                        evict_reg  <= 1'b0;
                        if (item_reg.kind == KIND_QUERY)
                        begin
                            result_reg.is_obsolete <= hit_reg
                                && !(item_reg.broadcast_id > $signed(hit_id_reg));
                            result_reg.is_same_id <= hit_reg
                                && (hit_id_reg == item_reg.broadcast_id);
                            done_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else if (hit_reg)
                        begin
                            if (id_older)
                            begin
                                result_reg.rejected <= 1'b1;
                                done_reg  <= 1'b1;
                                state_reg <= ST_IDLE;
                            end
                            else
                            begin
                                tgt_idx_reg  <= hit_idx_reg;
                                gap_reg      <= hit_rank_reg;
                                new_rank_reg <= used_m1[RANK_W-1:0];
                                cnt_reg      <= '0;
                                state_reg    <= ST_ADJUST;
                            end
                        end
                        else if (used_reg != CNT_W'(ENTRIES))
                        begin
                            valid_reg[free_idx_reg] <= 1'b1;
                            used_reg  <= used_reg + CNT_W'(1);
                            done_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            // full: oldest entry is overwritten as the newest
                            tgt_idx_reg  <= old_idx_reg;
                            gap_reg      <= '0;
                            new_rank_reg <= RANK_W'(ENTRIES - 1);
                            evict_reg    <= 1'b1;
                            cnt_reg      <= '0;
                            state_reg    <= ST_ADJUST;
                        end
                    end
                end
                ST_ADJUST:
                begin
                    if (pass_end)
                    begin
                        result_reg.evicted <= evict_reg;
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_done_single : assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe longer than one cycle");

    a_start_busy : assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("start transfer did not raise busy");

    a_fill_count : assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_reg) == 32'(used_reg))
        else $error("fill count does not match valid bits");

    a_no_rw_clash : assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_rd) |-> (mem_waddr != mem_raddr))
        else $error("slot memory read and write to same entry");

    a_flags_excl : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !((result.rejected || result.evicted)
                   && (result.is_obsolete || result.is_same_id)))
        else $error("query and add flags raised together");

endmodule

// ===== verif/broadcast_id_duplicate_cache_tb.sv =====
`timescale 1ns / 1ps

module broadcast_id_duplicate_cache_tb;

    import bidc_pkg::*;

    localparam int POOL_SIZE  = 22;
    localparam int SETTLE_CYC = 2 * ENTRIES + 10;

    logic    clk;
    logic    rst_n;
    logic    start;
    item_t   item;
    logic    busy;
    logic    done;
    result_t result;

    // cache shadow used to predict every result
    logic                       tbl_valid [ENTRIES];
    logic [ADDR_WIDTH-1:0]      tbl_source[ENTRIES];
    logic signed [ID_WIDTH-1:0] tbl_id    [ENTRIES];
    int                         tbl_rank  [ENTRIES];
    int                         tbl_count;

    result_t expected_results[$];
    result_t want;
    int      errors;
    int      transfers_done;
    int      n_obsolete;
    int      n_same;
    int      n_rejected;
    int      n_evicted;

    // sender pacing
    bit      bursty;
    int      burst_left;

    // traffic generator pool of recurring sources and their running ids
    logic [IN_ADDR_W-1:0]       addr_pool[POOL_SIZE];
    logic signed [ID_WIDTH-1:0] seq_pool [POOL_SIZE];

    broadcast_id_duplicate_cache uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5ms;
        $display("broadcast_id_duplicate_cache_tb: FAIL");
        $finish;
    end

    // every valid entry younger than rank r moves one step older
    function automatic void age_close_gap(input int r);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (tbl_valid[i] && tbl_rank[i] > r)
                tbl_rank[i] = tbl_rank[i] - 1;
        end
    endfunction

    function automatic result_t cache_lookup_update(input item_t it);
        result_t                    r;
        int                         hit;
        int                         slot;
        logic signed [ID_WIDTH-1:0] idv;
        logic [ADDR_WIDTH-1:0]      src;
        r    = '0;
        hit  = -1;
        slot = -1;
        idv  = it.broadcast_id;
        src  = ADDR_WIDTH'(it.source_addr);
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (hit < 0 && tbl_valid[i] && tbl_source[i] == src)
                hit = i;
        end
        if (it.kind == KIND_QUERY)
        begin
            if (hit >= 0)
            begin
                r.is_obsolete = (tbl_id[hit] >= idv);
                r.is_same_id  = (tbl_id[hit] == idv);
            end
        end
        else if (hit >= 0)
        begin
            if (tbl_id[hit] > idv)
                r.rejected = 1'b1;
            else
            begin
                age_close_gap(tbl_rank[hit]);
                tbl_id[hit]   = idv;
                tbl_rank[hit] = tbl_count - 1;
            end
        end
        else if (tbl_count < ENTRIES)
        begin
            for (int i = ENTRIES - 1; i >= 0; i--)
            begin
                if (!tbl_valid[i])
                    slot = i;
            end
            tbl_valid[slot]  = 1'b1;
            tbl_source[slot] = src;
            tbl_id[slot]     = idv;
            tbl_rank[slot]   = tbl_count;
            tbl_count++;
        end
        else
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (slot < 0 && tbl_valid[i] && tbl_rank[i] == 0)
                    slot = i;
            end
            age_close_gap(0);
            tbl_source[slot] = src;
            tbl_id[slot]     = idv;
            tbl_rank[slot]   = ENTRIES - 1;
            r.evicted        = 1'b1;
        end
        return r;
    endfunction

    function automatic item_t make_item(input logic k, input logic [31:0] src,
                                        input logic [31:0] id);
        item_t it;
        it.kind         = k;
        it.source_addr  = src;
        it.broadcast_id = id;
        return it;
    endfunction

    // one transfer: holds start until busy is sampled low at a rising edge
    task automatic send_item(input item_t it);
        int gap;
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_results.push_back(cache_lookup_update(it));
        if (bursty)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                gap = $urandom_range(1, 45);
                start <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = $urandom_range(0, 25);
            end
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_field(input string name, input logic e, input logic g);
        if (g !== e)
        begin
            $display("%0t: %s mismatch, expected %0b actual %0b", $time, name, e, g);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual %p", $time, result);
                errors++;
            end
            else
            begin
                want = expected_results.pop_front();
                report_field("is_obsolete", want.is_obsolete, result.is_obsolete);
                report_field("is_same_id", want.is_same_id, result.is_same_id);
                report_field("rejected", want.rejected, result.rejected);
                report_field("evicted", want.evicted, result.evicted);
                transfers_done++;
                n_obsolete += want.is_obsolete;
                n_same     += want.is_same_id;
                n_rejected += want.rejected;
                n_evicted  += want.evicted;
            end
        end
    end

    task automatic test_empty_lookup();
        send_item(make_item(KIND_QUERY, 32'h0000_0000, 32'h0000_0000));
        send_item(make_item(KIND_QUERY, 32'hFFFF_FFFF, 32'h8000_0000));
    endtask

    task automatic test_id_compare();
        send_item(make_item(KIND_ADD, 32'hFFFF_FFFF, 32'h0000_0000));
        send_item(make_item(KIND_ADD, 32'h0000_0000, 32'h7FFF_FFFF));
        send_item(make_item(KIND_QUERY, 32'hFFFF_FFFF, 32'h0000_0000));
        send_item(make_item(KIND_QUERY, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_item(make_item(KIND_QUERY, 32'hFFFF_FFFF, 32'h0000_0001));
        // older id on a known source must be refused
        send_item(make_item(KIND_ADD, 32'hFFFF_FFFF, 32'h8000_0000));
        send_item(make_item(KIND_ADD, 32'hFFFF_FFFF, 32'h0000_0000));
        send_item(make_item(KIND_ADD, 32'h0000_0000, 32'hFFFF_FFFF));
        send_item(make_item(KIND_ADD, 32'hFFFF_FFFF, 32'h7FFF_FFFF));
    endtask

    task automatic test_fill_and_evict();
        for (int i = 0; i < ENTRIES - 2; i++)
            send_item(make_item(KIND_ADD, 32'h1 << (i + 1), i * 32'h1111_1111));
        // full table, new source pushes out the oldest entry
        send_item(make_item(KIND_ADD, 32'hA5A5_5A5A, 32'h8000_0000));
        send_item(make_item(KIND_QUERY, 32'h0000_0000, 32'h8000_0000));
        send_item(make_item(KIND_QUERY, 32'hA5A5_5A5A, 32'h8000_0000));
    endtask

    task automatic seed_pool();
        for (int k = 0; k < POOL_SIZE; k++)
        begin
            addr_pool[k] = $urandom;
            seq_pool[k]  = ($urandom_range(0, 3) == 0) ? 32'h7FFF_FFF0 : $urandom;
        end
        addr_pool[0] = 32'h0000_0000;
        addr_pool[1] = 32'hFFFF_FFFF;
    endtask

    task automatic test_random_traffic(input int n_items);
        item_t it;
        int    k;
        int    off;
        for (int n = 0; n < n_items; n++)
        begin
            k = $urandom_range(0, POOL_SIZE - 1);
            it.kind = ($urandom_range(0, 99) < 45) ? KIND_ADD : KIND_QUERY;
            it.source_addr = ($urandom_range(0, 9) == 0) ? $urandom : addr_pool[k];
            off = int'($urandom_range(0, 6)) - 3;
            case ($urandom_range(0, 9))
                0:       it.broadcast_id = $urandom;
                1:       it.broadcast_id = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                default: it.broadcast_id = seq_pool[k] + off;
            endcase
            if (it.kind == KIND_ADD)
                seq_pool[k] = seq_pool[k] + 1;
            send_item(it);
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        item           = '0;
        errors         = 0;
        transfers_done = 0;
        n_obsolete     = 0;
        n_same         = 0;
        n_rejected     = 0;
        n_evicted      = 0;
        bursty         = 1'b0;
        burst_left     = 0;
        tbl_count      = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            tbl_valid[i] = 1'b0;
            tbl_rank[i]  = 0;
        end
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_lookup();
        test_id_compare();
        bursty = 1'b1;
        test_fill_and_evict();

        seed_pool();
        test_random_traffic(200);
        // hold off until the block has answered everything
        wait_drained();
        bursty = 1'b0;
        test_random_traffic(150);
        bursty = 1'b1;
        seed_pool();
        test_random_traffic(170);

        wait_drained();
        repeat (SETTLE_CYC) @(posedge clk);
        $display("covered %0d transfers: %0d obsolete, %0d same id, %0d rejected, %0d evicted",
                 transfers_done, n_obsolete, n_same, n_rejected, n_evicted);
        if (errors == 0)
            $display("broadcast_id_duplicate_cache_tb: PASS");
        else
            $display("broadcast_id_duplicate_cache_tb: FAIL");
        $finish;
    end

endmodule
